[hw/rtl/tlbg_pkg.sv]
// ----------------------------------------------------------------------------
// tlbg_pkg
// Shared widths and sideband type for the P1 triangle gradient pipeline.
// ----------------------------------------------------------------------------
package tlbg_pkg;

    localparam int CW    = 16;      // coordinate, Q8.8
    localparam int AW    = 17;      // edge difference
    localparam int DETW  = 34;      // determinant
    localparam int ADW   = 33;      // |det|
    localparam int NW    = 43;      // divider numerator 2*|a|*2^24 + |det|
    localparam int DVW   = 34;      // divider denominator 2*|det|
    localparam int GW    = 32;      // Q16.16 gradient
    localparam int QSW   = NW + 1;  // signed quotient
    localparam int SW    = NW + 2;  // signed sum for grad1
    localparam int NLANE = 4;

    typedef struct packed {
        logic [DETW-1:0]  det;
        logic [NLANE-1:0] neg;
        logic             deg;
    } t_side;

endpackage

[hw/rtl/tlbg_front.sv]
// ----------------------------------------------------------------------------
// tlbg_front
// Edge differences, determinant and divider operand set-up (four stages).
// ----------------------------------------------------------------------------
module tlbg_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [tlbg_pkg::CW-1:0] i_x0,
    input  logic signed [tlbg_pkg::CW-1:0] i_y0,
    input  logic signed [tlbg_pkg::CW-1:0] i_x1,
    input  logic signed [tlbg_pkg::CW-1:0] i_y1,
    input  logic signed [tlbg_pkg::CW-1:0] i_x2,
    input  logic signed [tlbg_pkg::CW-1:0] i_y2,
    output logic                         o_valid,
    output logic [tlbg_pkg::NW-1:0]      o_num [tlbg_pkg::NLANE],
    output logic [tlbg_pkg::DVW-1:0]     o_den,
    output tlbg_pkg::t_side              o_side
);

    logic [3:0] r_vld;

    // lanes: 0 = y2-y0, 1 = x0-x2, 2 = y0-y1, 3 = x1-x0
    logic signed [tlbg_pkg::AW-1:0]   r1_a [tlbg_pkg::NLANE];
    logic signed [tlbg_pkg::AW-1:0]   r2_a [tlbg_pkg::NLANE];
    logic signed [tlbg_pkg::AW-1:0]   r3_a [tlbg_pkg::NLANE];
    logic signed [tlbg_pkg::DETW-1:0] r2_p1, r2_p2, r3_det;
    logic [tlbg_pkg::NW-1:0]          r4_num [tlbg_pkg::NLANE];
    logic [tlbg_pkg::DVW-1:0]         r4_den;
    tlbg_pkg::t_side                  r4_side;

    logic [tlbg_pkg::ADW-1:0]  ad;
    logic [tlbg_pkg::AW-1:0]   aa [tlbg_pkg::NLANE];

    always_comb begin
        ad = r3_det[tlbg_pkg::DETW-1] ? tlbg_pkg::ADW'(-r3_det) : tlbg_pkg::ADW'(r3_det);
        for (int i = 0; i < tlbg_pkg::NLANE; i++) begin
            aa[i] = r3_a[i][tlbg_pkg::AW-1] ? tlbg_pkg::AW'(-r3_a[i]) : tlbg_pkg::AW'(r3_a[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a[0] <= {i_y2[tlbg_pkg::CW-1], i_y2} - {i_y0[tlbg_pkg::CW-1], i_y0};
        r1_a[1] <= {i_x0[tlbg_pkg::CW-1], i_x0} - {i_x2[tlbg_pkg::CW-1], i_x2};
        r1_a[2] <= {i_y0[tlbg_pkg::CW-1], i_y0} - {i_y1[tlbg_pkg::CW-1], i_y1};
        r1_a[3] <= {i_x1[tlbg_pkg::CW-1], i_x1} - {i_x0[tlbg_pkg::CW-1], i_x0};

        r2_a  <= r1_a;
        r2_p1 <= r1_a[3] * r1_a[0];
        r2_p2 <= r1_a[2] * r1_a[1];

        r3_a   <= r2_a;
        r3_det <= r2_p1 - r2_p2;

        for (int i = 0; i < tlbg_pkg::NLANE; i++) begin
            r4_num[i]      <= tlbg_pkg::NW'({aa[i], 25'd0}) + tlbg_pkg::NW'(ad);
            r4_side.neg[i] <= r3_a[i][tlbg_pkg::AW-1] ^ r3_det[tlbg_pkg::DETW-1];
        end
        r4_den       <= {ad, 1'b0};
        r4_side.det  <= r3_det;
        r4_side.deg  <= (r3_det == '0);
    end

    assign o_valid = r_vld[3];
    assign o_num   = r4_num;
    assign o_den   = r4_den;
    assign o_side  = r4_side;

endmodule

[hw/rtl/tlbg_div.sv]
// ----------------------------------------------------------------------------
// tlbg_div
// Four-lane restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module tlbg_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [tlbg_pkg::NW-1:0]  i_num [tlbg_pkg::NLANE],
    input  logic [tlbg_pkg::DVW-1:0] i_den,
    input  tlbg_pkg::t_side          i_side,
    output logic                     o_valid,
    output logic [tlbg_pkg::NW-1:0]  o_quo [tlbg_pkg::NLANE],
    output tlbg_pkg::t_side          o_side
);

    localparam int NST = tlbg_pkg::NW;

    logic                     r_vld  [NST+1];
    logic [tlbg_pkg::DVW-1:0] r_rem  [NST+1][tlbg_pkg::NLANE];
    logic [tlbg_pkg::NW-1:0]  r_nq   [NST+1][tlbg_pkg::NLANE];
    logic [tlbg_pkg::DVW-1:0] r_den  [NST+1];
    tlbg_pkg::t_side          r_side [NST+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_den[0]  = i_den;
        r_side[0] = i_side;
        for (int i = 0; i < tlbg_pkg::NLANE; i++) begin
            r_rem[0][i] = '0;
            r_nq[0][i]  = i_num[i];
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [tlbg_pkg::DVW:0]   t     [tlbg_pkg::NLANE];
        logic [tlbg_pkg::DVW:0]   diff  [tlbg_pkg::NLANE];
        logic [tlbg_pkg::DVW-1:0] n_rem [tlbg_pkg::NLANE];
        logic [tlbg_pkg::NW-1:0]  n_nq  [tlbg_pkg::NLANE];

        always_comb begin
            for (int i = 0; i < tlbg_pkg::NLANE; i++) begin
                t[i]    = {r_rem[s][i], r_nq[s][i][tlbg_pkg::NW-1]};
                diff[i] = t[i] - {1'b0, r_den[s]};
                if (t[i] >= {1'b0, r_den[s]}) begin
                    n_rem[i] = diff[i][tlbg_pkg::DVW-1:0];
                    n_nq[i]  = {r_nq[s][i][tlbg_pkg::NW-2:0], 1'b1};
                end else begin
                    n_rem[i] = t[i][tlbg_pkg::DVW-1:0];
                    n_nq[i]  = {r_nq[s][i][tlbg_pkg::NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= n_rem;
            r_nq[s+1]   <= n_nq;
            r_den[s+1]  <= r_den[s];
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_vld[NST];
    assign o_quo   = r_nq[NST];
    assign o_side  = r_side[NST];

endmodule

[hw/rtl/tlbg_back.sv]
// ----------------------------------------------------------------------------
// tlbg_back
// Quotient sign, grad1 sum, Q16.16 clipping, degenerate zeroing, output regs.
// ----------------------------------------------------------------------------
module tlbg_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [tlbg_pkg::NW-1:0]   i_quo [tlbg_pkg::NLANE],
    input  tlbg_pkg::t_side           i_side,
    output logic                      o_valid,
    output logic [tlbg_pkg::GW-1:0]   o_grad [6],
    output logic [tlbg_pkg::DETW-1:0] o_det,
    output logic                      o_deg,
    output logic                      o_sat
);

    localparam logic signed [tlbg_pkg::SW-1:0] GMAX = (tlbg_pkg::SW'(1) <<< (tlbg_pkg::GW-1)) - 1;
    localparam logic signed [tlbg_pkg::SW-1:0] GMIN = -(tlbg_pkg::SW'(1) <<< (tlbg_pkg::GW-1));

    logic                            r1_vld, r2_vld;
    logic signed [tlbg_pkg::SW-1:0]  r1_g [6];
    tlbg_pkg::t_side                 r1_side;
    logic [tlbg_pkg::GW-1:0]         r2_grad [6];
    logic [tlbg_pkg::DETW-1:0]       r2_det;
    logic                            r2_deg, r2_sat;

    logic signed [tlbg_pkg::QSW-1:0] qs [tlbg_pkg::NLANE];
    logic [tlbg_pkg::GW-1:0]         n_grad [6];
    logic [5:0]                      clipped;

    always_comb begin
        for (int i = 0; i < tlbg_pkg::NLANE; i++) begin
            qs[i] = i_side.neg[i] ? -$signed({1'b0, i_quo[i]}) : $signed({1'b0, i_quo[i]});
        end
        for (int k = 0; k < 6; k++) begin
            if (r1_g[k] > GMAX) begin
                clipped[k] = 1'b1;
                n_grad[k]  = GMAX[tlbg_pkg::GW-1:0];
            end else if (r1_g[k] < GMIN) begin
                clipped[k] = 1'b1;
                n_grad[k]  = GMIN[tlbg_pkg::GW-1:0];
            end else begin
                clipped[k] = 1'b0;
                n_grad[k]  = r1_g[k][tlbg_pkg::GW-1:0];
            end
            if (r1_side.deg) begin
                clipped[k] = 1'b0;
                n_grad[k]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_g[2] <= tlbg_pkg::SW'(qs[0]);
        r1_g[3] <= tlbg_pkg::SW'(qs[1]);
        r1_g[4] <= tlbg_pkg::SW'(qs[2]);
        r1_g[5] <= tlbg_pkg::SW'(qs[3]);
        r1_g[0] <= -tlbg_pkg::SW'(qs[0]) - tlbg_pkg::SW'(qs[2]);
        r1_g[1] <= -tlbg_pkg::SW'(qs[1]) - tlbg_pkg::SW'(qs[3]);
        r1_side <= i_side;

        r2_grad <= n_grad;
        r2_det  <= r1_side.det;
        r2_deg  <= r1_side.deg;
        r2_sat  <= |clipped;
    end

    assign o_valid = r2_vld;
    assign o_grad  = r2_grad;
    assign o_det   = r2_det;
    assign o_deg   = r2_deg;
    assign o_sat   = r2_sat;

endmodule

[hw/rtl/triangle_linear_basis_gradients_core.sv]
// ----------------------------------------------------------------------------
// triangle_linear_basis_gradients_core
// P1 basis gradients of a triangle in Q16.16, with determinant and flags.
// ----------------------------------------------------------------------------
// A new triangle may be started in every cycle; busy is always low. Each item
// gives its result, marked by o_valid for one cycle, after four set-up stages,
// 43 stages of the bit-per-stage divider (one per quotient bit) and two stages
// for sign, sum and clipping. Results cannot be held off by the receiver.
module triangle_linear_basis_gradients_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [tlbg_pkg::CW-1:0]  i_x0,
    input  logic signed [tlbg_pkg::CW-1:0]  i_y0,
    input  logic signed [tlbg_pkg::CW-1:0]  i_x1,
    input  logic signed [tlbg_pkg::CW-1:0]  i_y1,
    input  logic signed [tlbg_pkg::CW-1:0]  i_x2,
    input  logic signed [tlbg_pkg::CW-1:0]  i_y2,
    output logic                            o_valid,
    output logic signed [tlbg_pkg::GW-1:0]  o_grad1_x,
    output logic signed [tlbg_pkg::GW-1:0]  o_grad1_y,
    output logic signed [tlbg_pkg::GW-1:0]  o_grad2_x,
    output logic signed [tlbg_pkg::GW-1:0]  o_grad2_y,
    output logic signed [tlbg_pkg::GW-1:0]  o_grad3_x,
    output logic signed [tlbg_pkg::GW-1:0]  o_grad3_y,
    output logic signed [tlbg_pkg::DETW-1:0] o_jacobian_det,
    output logic                            o_degenerate,
    output logic                            o_saturated
);

    logic                     f_vld, d_vld;
    logic [tlbg_pkg::NW-1:0]  f_num [tlbg_pkg::NLANE];
    logic [tlbg_pkg::NW-1:0]  d_quo [tlbg_pkg::NLANE];
    logic [tlbg_pkg::DVW-1:0] f_den;
    tlbg_pkg::t_side          f_side, d_side;
    logic [tlbg_pkg::GW-1:0]  grad [6];
    logic [tlbg_pkg::DETW-1:0] det;

    assign busy = 1'b0;

    tlbg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_x0    (i_x0),
        .i_y0    (i_y0),
        .i_x1    (i_x1),
        .i_y1    (i_y1),
        .i_x2    (i_x2),
        .i_y2    (i_y2),
        .o_valid (f_vld),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    tlbg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_vld),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    tlbg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_vld),
        .i_quo   (d_quo),
        .i_side  (d_side),
        .o_valid (o_valid),
        .o_grad  (grad),
        .o_det   (det),
        .o_deg   (o_degenerate),
        .o_sat   (o_saturated)
    );

    assign o_grad1_x      = grad[0];
    assign o_grad1_y      = grad[1];
    assign o_grad2_x      = grad[2];
    assign o_grad2_y      = grad[3];
    assign o_grad3_x      = grad[4];
    assign o_grad3_y      = grad[5];
    assign o_jacobian_det = det;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##49 o_valid) else $error("item lost in pipeline");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_jacobian_det == '0 && o_grad1_x == '0 &&
        o_grad2_y == '0 && o_grad3_x == '0 && !o_saturated)
        else $error("degenerate result not cleared");

    a_deg_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_jacobian_det != '0)
        else $error("non-degenerate result with zero determinant");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the P1 triangle basis gradient core.
// Triangles are driven from a queue of pending items and predicted at the
// moment the core takes them. The expected gradients, determinant and flags
// are then compared with each strobed result. The run passes through phases
// with different sender idling, including one pause until the pipe drains.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [tlbg_pkg::CW-1:0] x0, y0, x1, y1, x2, y2;
    } t_tri;

    typedef struct {
        logic signed [tlbg_pkg::GW-1:0]   g1x, g1y, g2x, g2y, g3x, g3y;
        logic signed [tlbg_pkg::DETW-1:0] det;
        logic                             deg, sat;
    } t_grad;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic signed [tlbg_pkg::CW-1:0]   i_x0, i_y0, i_x1, i_y1, i_x2, i_y2;
    logic                             o_valid;
    logic signed [tlbg_pkg::GW-1:0]   o_grad1_x, o_grad1_y, o_grad2_x, o_grad2_y;
    logic signed [tlbg_pkg::GW-1:0]   o_grad3_x, o_grad3_y;
    logic signed [tlbg_pkg::DETW-1:0] o_jacobian_det;
    logic                             o_degenerate, o_saturated;

    t_tri  pending_tris[$];
    t_grad expected_grads[$];
    int    idle_pct = 0;
    bit    hold_off = 0;
    int    n_errors = 0;
    int    n_results = 0;
    int    n_degen = 0;
    int    n_sat = 0;

    triangle_linear_basis_gradients_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x0          (i_x0),
        .i_y0          (i_y0),
        .i_x1          (i_x1),
        .i_y1          (i_y1),
        .i_x2          (i_x2),
        .i_y2          (i_y2),
        .o_valid       (o_valid),
        .o_grad1_x     (o_grad1_x),
        .o_grad1_y     (o_grad1_y),
        .o_grad2_x     (o_grad2_x),
        .o_grad2_y     (o_grad2_y),
        .o_grad3_x     (o_grad3_x),
        .o_grad3_y     (o_grad3_y),
        .o_jacobian_det(o_jacobian_det),
        .o_degenerate  (o_degenerate),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // rounded num * 2^24 / den, ties away from zero
    function automatic longint scaled_quotient(longint num, longint den);
        bit     neg;
        longint n, d, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0 ? -num : num) <<< 24;
        d = den < 0 ? -den : den;
        q = (2 * n + d) / (2 * d);
        return neg ? -q : q;
    endfunction

    function automatic logic signed [tlbg_pkg::GW-1:0] clip_q16(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[tlbg_pkg::GW-1:0];
    endfunction

    function automatic t_grad basis_gradients(t_tri t);
        t_grad  r;
        longint a2x, a2y, a3x, a3y, det, g2x, g2y, g3x, g3y;
        bit     sat;
        sat = 1'b0;
        a2x = longint'(t.y2) - longint'(t.y0);
        a2y = longint'(t.x0) - longint'(t.x2);
        a3x = longint'(t.y0) - longint'(t.y1);
        a3y = longint'(t.x1) - longint'(t.x0);
        det = a3y * a2x - a3x * a2y;
        r = '{default: '0};
        r.det = det[tlbg_pkg::DETW-1:0];
        r.deg = (det == 0);
        if (det != 0) begin
            g2x = scaled_quotient(a2x, det);
            g2y = scaled_quotient(a2y, det);
            g3x = scaled_quotient(a3x, det);
            g3y = scaled_quotient(a3y, det);
            r.g1x = clip_q16(-g2x - g3x, sat);
            r.g1y = clip_q16(-g2y - g3y, sat);
            r.g2x = clip_q16(g2x, sat);
            r.g2y = clip_q16(g2y, sat);
            r.g3x = clip_q16(g3x, sat);
            r.g3y = clip_q16(g3y, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off || pending_tris.size() == 0 ||
            $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
        end else begin
            start <= 1'b1;
            i_x0  <= pending_tris[0].x0;
            i_y0  <= pending_tris[0].y0;
            i_x1  <= pending_tris[0].x1;
            i_y1  <= pending_tris[0].y1;
            i_x2  <= pending_tris[0].x2;
            i_y2  <= pending_tris[0].y2;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_tri  t;
        t_grad e;
        if (i_rst_n) begin
            if (start && !busy) begin
                t = '{i_x0, i_y0, i_x1, i_y1, i_x2, i_y2};
                expected_grads.push_back(basis_gradients(t));
                void'(pending_tris.pop_front());
            end
            if (o_valid) begin
                n_results++;
                if (expected_grads.size() == 0) begin
                    $error("result with no triangle outstanding");
                    n_errors++;
                end else begin
                    e = expected_grads.pop_front();
                    if (e.deg) n_degen++;
                    if (e.sat) n_sat++;
                    if (o_grad1_x !== e.g1x) begin
                        $error("grad1_x exp %0d got %0d", e.g1x, o_grad1_x); n_errors++;
                    end
                    if (o_grad1_y !== e.g1y) begin
                        $error("grad1_y exp %0d got %0d", e.g1y, o_grad1_y); n_errors++;
                    end
                    if (o_grad2_x !== e.g2x) begin
                        $error("grad2_x exp %0d got %0d", e.g2x, o_grad2_x); n_errors++;
                    end
                    if (o_grad2_y !== e.g2y) begin
                        $error("grad2_y exp %0d got %0d", e.g2y, o_grad2_y); n_errors++;
                    end
                    if (o_grad3_x !== e.g3x) begin
                        $error("grad3_x exp %0d got %0d", e.g3x, o_grad3_x); n_errors++;
                    end
                    if (o_grad3_y !== e.g3y) begin
                        $error("grad3_y exp %0d got %0d", e.g3y, o_grad3_y); n_errors++;
                    end
                    if (o_jacobian_det !== e.det) begin
                        $error("jacobian_det exp %0d got %0d", e.det, o_jacobian_det);
                        n_errors++;
                    end
                    if (o_degenerate !== e.deg) begin
                        $error("degenerate exp %0d got %0d", e.deg, o_degenerate);
                        n_errors++;
                    end
                    if (o_saturated !== e.sat) begin
                        $error("saturated exp %0d got %0d", e.sat, o_saturated);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic add_tri(int x0, int y0, int x1, int y1, int x2, int y2);
        t_tri t;
        t = '{x0[tlbg_pkg::CW-1:0], y0[tlbg_pkg::CW-1:0],
              x1[tlbg_pkg::CW-1:0], y1[tlbg_pkg::CW-1:0],
              x2[tlbg_pkg::CW-1:0], y2[tlbg_pkg::CW-1:0]};
        pending_tris.push_back(t);
    endtask

    function automatic int rnd_coord(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic add_random(int n);
        int k, kind, x0, y0, dx, dy, m;
        for (k = 0; k < n; k++) begin
            kind = $urandom_range(9);
            x0 = rnd_coord(32768);
            y0 = rnd_coord(32768);
            case (kind)
                0, 1, 2: begin
                    add_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
                3: begin
                    // collinear vertices
                    dx = rnd_coord(64);
                    dy = rnd_coord(64);
                    m = rnd_coord(8);
                    add_tri(x0, y0, x0 + dx, y0 + dy, x0 + m * dx, y0 + m * dy);
                end
                4: begin
                    // near-degenerate sliver, tends to saturate
                    dx = rnd_coord(32767);
                    dy = rnd_coord(32767);
                    add_tri(0, 0, dx, dy, dx + rnd_coord(2), dy + rnd_coord(2));
                end
                5, 6: begin
                    add_tri(x0, y0, x0 + rnd_coord(16), y0 + rnd_coord(16),
                            x0 + rnd_coord(16), y0 + rnd_coord(16));
                end
                default: begin
                    add_tri(rnd_coord(2048), rnd_coord(2048), rnd_coord(2048),
                            rnd_coord(2048), rnd_coord(2048), rnd_coord(2048));
                end
            endcase
        end
    endtask

    task automatic drain_pending();
        while (pending_tris.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        start   = 1'b0;
        i_x0    = '0;
        i_y0    = '0;
        i_x1    = '0;
        i_y1    = '0;
        i_x2    = '0;
        i_y2    = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_tri(0, 0, 0, 0, 0, 0);
        add_tri(-32768, -32768, -32768, -32768, -32768, -32768);
        add_tri(0, 0, 256, 0, 0, 256);
        add_tri(0, 0, 0, 256, 256, 0);
        add_tri(-32768, -32768, 32767, -32768, -32768, 32767);
        add_tri(32767, 32767, -32768, 32767, 32767, -32768);
        add_tri(-32768, 32767, 32767, -32768, 32767, 32767);
        add_tri(0, 0, 1, 0, 32767, 1);
        add_tri(0, 0, 1, 0, -32768, 1);
        add_tri(0, 0, 1, 0, 0, 1);
        add_tri(0, 0, 3, 0, 0, 3);
        add_tri(0, 0, 2, 1, 1, 2);
        add_tri(100, 100, 200, 200, 300, 300);
        add_tri(-32768, 0, 32767, 0, 0, 1);
        add_tri(5, -7, 5, -7, 1000, 42);
        add_tri(0, 0, 32767, 32767, 32766, 32767);
        add_tri(1, 1, -1, -1, 1, -1);
        add_tri(0, 0, 65535, 0, 0, 65535);
        drain_pending();

        add_random(450);
        drain_pending();

        hold_off = 1'b1;
        while (expected_grads.size() != 0) @(posedge i_clk);
        hold_off = 1'b0;

        idle_pct = 67;
        add_random(400);
        drain_pending();

        idle_pct = 0;
        add_random(300);
        drain_pending();

        idle_pct = 10;
        add_random(380);
        drain_pending();

        while (expected_grads.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (expected_grads.size() != 0) begin
            $error("%0d results never arrived", expected_grads.size());
            n_errors++;
        end
        $display("Checked %0d triangles: %0d degenerate, %0d with clipped gradients,",
                 n_results, n_degen, n_sat);
        $display("over phases with no idling, heavy and light sender gaps and a full drain.");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
